// File: hdl/tit_pkg.sv
// Shared constants for the target intercept tracker.
// Used by target_intercept_tracker, tit_div and tit_sqrt; no dependencies.
`default_nettype none
package tit_pkg;

	localparam int HIST_DEPTH = 10;
	localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
	localparam int HIST_CNT_W = $clog2(HIST_DEPTH + 1);

	localparam int COORD_W = 11;
	localparam int DIFF_W  = 12;
	localparam int VEL_W   = 13;
	localparam int SUM_W   = VEL_W + HIST_CNT_W;
	localparam int AVG_W   = 21;
	localparam int AIM_W   = 16;

	localparam int SPEED_W   = 6;
	localparam int TOL_W     = 4;
	localparam int CFG_IDX_W = 1;
	localparam logic [SPEED_W-1:0]   SPEED_RST = 6'd10;
	localparam logic [TOL_W-1:0]     TOL_RST   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TOL   = 1'b1;

	// shared serial units
	localparam int DIV_NW = 52;
	localparam int DIV_DW = 44;
	localparam int SQ_W   = 52;
	localparam int SQ_RW  = SQ_W / 2;
	localparam int MUL_W  = 33;

endpackage
`default_nettype wire

// File: hdl/tit_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tit_pkg for operand widths.
`default_nettype none
module tit_div
	import tit_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire [DIV_NW-1:0]  num,
	input  wire [DIV_DW-1:0]  den,
	output logic              done,
	output logic [DIV_NW-1:0] quot
);

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DIV_NW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= DIV_DW'(trial - {1'b0, den_q});
				quo_q <= {quo_q[DIV_NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

// File: hdl/tit_sqrt.sv
// Bit-pair integer square root, floor result, one root bit per cycle.
// Depends on tit_pkg for radicand and root widths.
`default_nettype none
module tit_sqrt
	import tit_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire [SQ_W-1:0]   rad,
	output logic             done,
	output logic [SQ_RW-1:0] root
);

	localparam int CNT_W = $clog2(SQ_RW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [SQ_W-1:0]  rad_q;
	logic [SQ_RW:0]   rem_q;
	logic [SQ_RW-1:0] root_q;
	logic [SQ_RW+2:0] cand;
	logic [SQ_RW+2:0] trial;

	assign cand  = {rem_q, rad_q[SQ_W-1:SQ_W-2]};
	assign trial = (SQ_RW+3)'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(SQ_RW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q <= {rad_q[SQ_W-3:0], 2'b00};
			if (cand >= trial) begin
				rem_q  <= (SQ_RW+1)'(cand - trial);
				root_q <= {root_q[SQ_RW-2:0], 1'b1};
			end else begin
				rem_q  <= cand[SQ_RW:0];
				root_q <= {root_q[SQ_RW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// File: hdl/target_intercept_tracker.sv
// With a velocity stored, a request can go through the history sum, two divides, the
// multiplier steps, a square root unless speeds match, and a time divide; else none.
// Throughput: one frame at a time; next request is taken the cycle after the result leaves.
// The 33x33 multiplier is shared by all product steps, the divider by all divides.
// Reset (async, active low): history zero and invalid, previous positions not found,
// projectile_speed = 10, jump_tolerance = 2.
`default_nettype none
module target_intercept_tracker
	import tit_pkg::*;
(
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire [CFG_IDX_W-1:0]       cfg_idx,
	input  wire [SPEED_W-1:0]         cfg_wdata,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire                       shooter_found,
	input  wire [COORD_W-1:0]         shooter_x,
	input  wire [COORD_W-1:0]         shooter_y,
	input  wire                       target_found,
	input  wire [COORD_W-1:0]         target_x,
	input  wire [COORD_W-1:0]         target_y,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic                      track_valid,
	output logic signed [AVG_W-1:0]   avg_vel_x,
	output logic signed [AVG_W-1:0]   avg_vel_y,
	output logic                      aim_valid,
	output logic signed [AIM_W-1:0]   aim_dx,
	output logic signed [AIM_W-1:0]   aim_dy
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MARK, ST_SUM, ST_CHK, ST_DIVX, ST_DIVY, ST_MUL,
		ST_DEC, ST_SQRT, ST_ROOT, ST_DIVT, ST_AIM, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		MS_AXDX, MS_AYDY, MS_DXDX, MS_DYDY, MS_AXAX, MS_AYAY, MS_SPSP,
		MS_AXDY, MS_AYDX, MS_LIM, MS_CR2, MS_C2, MA_X, MA_Y, MA_END
	} step_t;

	localparam logic [HIST_IDX_W-1:0] IDX_LAST = HIST_IDX_W'(HIST_DEPTH - 1);
	localparam logic signed [AIM_W-1:0] AIM_MAX = {1'b0, {(AIM_W-1){1'b1}}};
	localparam logic signed [AIM_W-1:0] AIM_MIN = {1'b1, {(AIM_W-1){1'b0}}};

	state_t state_q;
	step_t  step_q;

	logic [SPEED_W-1:0] speed_q;
	logic [TOL_W-1:0]   tol_q;

	logic               prev_sf_q, prev_tf_q;
	logic [COORD_W-1:0] prev_sx_q, prev_sy_q, prev_tx_q, prev_ty_q;

	logic signed [VEL_W-1:0] vel_x_q [HIST_DEPTH];
	logic signed [VEL_W-1:0] vel_y_q [HIST_DEPTH];
	logic [HIST_DEPTH-1:0]   marks_q;

	logic [HIST_IDX_W-1:0]   idx_q;
	logic signed [SUM_W-1:0] sumx_q, sumy_q;
	logic [HIST_CNT_W-1:0]   cnt_q;

	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic signed [AVG_W-1:0]  avx_q, avy_q;
	logic signed [63:0]       prod_q;
	logic signed [33:0]       dot_q, cr_q;
	logic [23:0]              dist2_q;
	logic [41:0]              u2_q;
	logic [27:0]              v2_q;
	logic [51:0]              lim_q;
	logic [63:0]              c2_q;
	logic [SQ_RW-1:0]         s_q;
	logic                     tneg_q;
	logic signed [31:0]       t_q;

	logic                     track_q, aim_q;
	logic signed [AIM_W-1:0]  aimx_q, aimy_q;

	logic              div_go_q, sq_go_q;
	logic [DIV_NW-1:0] div_num_q;
	logic [DIV_DW-1:0] div_den_q;
	logic [SQ_W-1:0]   sq_rad_q;
	logic              div_done, sq_done;
	logic [DIV_NW-1:0] div_quot;
	logic [SQ_RW-1:0]  sq_root;

	// input masking and new entry
	logic [COORD_W-1:0]      sx_m, sy_m, tx_m, ty_m;
	logic                    all_found;
	logic [VEL_W:0]          nvx_w, nvy_w;
	assign sx_m = shooter_found ? shooter_x : '0;
	assign sy_m = shooter_found ? shooter_y : '0;
	assign tx_m = target_found ? target_x : '0;
	assign ty_m = target_found ? target_y : '0;
	assign all_found = shooter_found && target_found && prev_sf_q && prev_tf_q;
	assign nvx_w = ((VEL_W+1)'(tx_m) - (VEL_W+1)'(prev_tx_q))
		- ((VEL_W+1)'(sx_m) - (VEL_W+1)'(prev_sx_q));
	assign nvy_w = ((VEL_W+1)'(ty_m) - (VEL_W+1)'(prev_ty_q))
		- ((VEL_W+1)'(sy_m) - (VEL_W+1)'(prev_sy_q));

	// neighbor checks over the history, one x/y compare pair per adjacent pair of slots
	logic [HIST_DEPTH-2:0] pair_ok;
	always_comb begin
		logic signed [VEL_W:0] ddx, ddy;
		logic [VEL_W:0]        adx, ady;
		for (int i = 0; i < HIST_DEPTH - 1; i++) begin
			ddx = (VEL_W+1)'(vel_x_q[i]) - (VEL_W+1)'(vel_x_q[i+1]);
			ddy = (VEL_W+1)'(vel_y_q[i]) - (VEL_W+1)'(vel_y_q[i+1]);
			adx = ddx[VEL_W] ? -ddx : ddx;
			ady = ddy[VEL_W] ? -ddy : ddy;
			pair_ok[i] = (adx <= (VEL_W+1)'(tol_q)) && (ady <= (VEL_W+1)'(tol_q));
		end
	end

	// shared multiplier operand select
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_p;
	logic [33:0]               cr_abs;
	assign cr_abs = cr_q[33] ? 34'(-cr_q) : 34'(cr_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			MS_AXDX: begin mul_a = MUL_W'(avx_q); mul_b = MUL_W'(dx_q); end
			MS_AYDY: begin mul_a = MUL_W'(avy_q); mul_b = MUL_W'(dy_q); end
			MS_DXDX: begin mul_a = MUL_W'(dx_q);  mul_b = MUL_W'(dx_q); end
			MS_DYDY: begin mul_a = MUL_W'(dy_q);  mul_b = MUL_W'(dy_q); end
			MS_AXAX: begin mul_a = MUL_W'(avx_q); mul_b = MUL_W'(avx_q); end
			MS_AYAY: begin mul_a = MUL_W'(avy_q); mul_b = MUL_W'(avy_q); end
			MS_SPSP: begin mul_a = MUL_W'(speed_q); mul_b = MUL_W'(speed_q); end
			MS_AXDY: begin mul_a = MUL_W'(avx_q); mul_b = MUL_W'(dy_q); end
			MS_AYDX: begin mul_a = MUL_W'(avy_q); mul_b = MUL_W'(dx_q); end
			MS_LIM:  begin mul_a = MUL_W'(dist2_q); mul_b = MUL_W'(v2_q); end
			MS_CR2:  begin mul_a = MUL_W'(cr_abs[32:0]); mul_b = MUL_W'(cr_abs[32:0]); end
			MA_X:    begin mul_a = MUL_W'(avx_q); mul_b = MUL_W'(t_q); end
			MA_Y:    begin mul_a = MUL_W'(avy_q); mul_b = MUL_W'(t_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// decision terms
	logic [33:0]        dot_abs;
	logic               speeds_eq, disc_pos;
	logic [51:0]        disc;
	logic signed [34:0] num_v;
	logic               root_ok;
	logic [34:0]        num_abs;
	logic signed [42:0] den_v;
	logic [42:0]        den_abs;
	assign dot_abs   = dot_q[33] ? 34'(-dot_q) : 34'(dot_q);
	assign speeds_eq = (u2_q == 42'(v2_q));
	assign disc_pos  = 64'(lim_q) > c2_q;
	assign disc      = 52'(64'(lim_q) - c2_q);
	assign den_v     = $signed(43'(v2_q)) - $signed(43'(u2_q));
	assign den_abs   = den_v[42] ? 43'(-den_v) : 43'(den_v);

	always_comb begin
		root_ok = 1'b1;
		num_v   = '0;
		if (dot_abs < 34'(s_q)) begin
			num_v = 35'(dot_q) + $signed(35'(s_q));
		end else if (!dot_q[33] && dot_q != '0) begin
			num_v = 35'(dot_q) - $signed(35'(s_q));
		end else begin
			root_ok = 1'b0;
		end
	end
	assign num_abs = num_v[34] ? 35'(-num_v) : 35'(num_v);

	// lead offset from a registered product, rounded by 2^16 and saturated
	logic [63:0]             p_abs;
	logic [37:0]             lead_mag;
	logic signed [39:0]      lead_s, lead_v, tot;
	logic signed [DIFF_W-1:0] d_sel;
	logic signed [AIM_W-1:0] aim_sat;
	assign p_abs    = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
	assign lead_mag = 38'((p_abs + 64'd32768) >> 16);
	assign lead_s   = $signed({2'b00, lead_mag});
	assign lead_v   = prod_q[63] ? -lead_s : lead_s;
	assign d_sel    = (step_q == MA_Y) ? dx_q : dy_q;
	assign tot      = 40'(d_sel) + lead_v;
	assign aim_sat  = (tot > 40'(AIM_MAX)) ? AIM_MAX :
		(tot < 40'(AIM_MIN)) ? AIM_MIN : tot[AIM_W-1:0];

	// time saturation
	logic signed [31:0] t_sat;
	always_comb begin
		if (tneg_q) begin
			t_sat = (div_quot > DIV_NW'(32'h8000_0000)) ? 32'sh8000_0000
				: 32'(-$signed({1'b0, div_quot[31:0]}));
		end else begin
			t_sat = (div_quot > DIV_NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
				: $signed(div_quot[31:0]);
		end
	end

	logic [SUM_W-1:0] sx_abs, sy_abs;
	assign sx_abs = sumx_q[SUM_W-1] ? SUM_W'(-sumx_q) : SUM_W'(sumx_q);
	assign sy_abs = sumy_q[SUM_W-1] ? SUM_W'(-sumy_q) : SUM_W'(sumy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= MS_AXDX;
			speed_q   <= SPEED_RST;
			tol_q     <= TOL_RST;
			prev_sf_q <= 1'b0;
			prev_tf_q <= 1'b0;
			prev_sx_q <= '0;
			prev_sy_q <= '0;
			prev_tx_q <= '0;
			prev_ty_q <= '0;
			for (int i = 0; i < HIST_DEPTH; i++) begin
				vel_x_q[i] <= '0;
				vel_y_q[i] <= '0;
			end
			marks_q   <= '0;
			idx_q     <= '0;
			sumx_q    <= '0;
			sumy_q    <= '0;
			cnt_q     <= '0;
			dx_q      <= '0;
			dy_q      <= '0;
			avx_q     <= '0;
			avy_q     <= '0;
			prod_q    <= '0;
			dot_q     <= '0;
			cr_q      <= '0;
			dist2_q   <= '0;
			u2_q      <= '0;
			v2_q      <= '0;
			lim_q     <= '0;
			c2_q      <= '0;
			s_q       <= '0;
			tneg_q    <= 1'b0;
			t_q       <= '0;
			track_q   <= 1'b0;
			aim_q     <= 1'b0;
			aimx_q    <= '0;
			aimy_q    <= '0;
			div_go_q  <= 1'b0;
			sq_go_q   <= 1'b0;
			div_num_q <= '0;
			div_den_q <= '0;
			sq_rad_q  <= '0;
		end else begin
			div_go_q <= 1'b0;
			sq_go_q  <= 1'b0;
			prod_q   <= mul_p[63:0];

			if (cfg_we) begin
				unique case (cfg_idx)
					REG_SPEED: speed_q <= cfg_wdata;
					REG_TOL:   tol_q   <= cfg_wdata[TOL_W-1:0];
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						for (int i = 0; i < HIST_DEPTH - 1; i++) begin
							vel_x_q[i] <= vel_x_q[i+1];
							vel_y_q[i] <= vel_y_q[i+1];
						end
						marks_q <= {1'b0, marks_q[HIST_DEPTH-1:1]};
						prev_sf_q <= shooter_found;
						prev_tf_q <= target_found;
						prev_sx_q <= sx_m;
						prev_sy_q <= sy_m;
						prev_tx_q <= tx_m;
						prev_ty_q <= ty_m;
						dx_q    <= $signed(DIFF_W'(tx_m)) - $signed(DIFF_W'(sx_m));
						dy_q    <= $signed(DIFF_W'(ty_m)) - $signed(DIFF_W'(sy_m));
						track_q <= 1'b0;
						aim_q   <= 1'b0;
						avx_q   <= '0;
						avy_q   <= '0;
						aimx_q  <= '0;
						aimy_q  <= '0;
						if (all_found) begin
							vel_x_q[HIST_DEPTH-1] <= nvx_w[VEL_W-1:0];
							vel_y_q[HIST_DEPTH-1] <= nvy_w[VEL_W-1:0];
							state_q <= ST_MARK;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_MARK: begin
					marks_q <= marks_q | HIST_DEPTH'(pair_ok) | {pair_ok, 1'b0};
					idx_q   <= '0;
					sumx_q  <= '0;
					sumy_q  <= '0;
					cnt_q   <= '0;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (marks_q[idx_q]) begin
						sumx_q <= sumx_q + SUM_W'(vel_x_q[idx_q]);
						sumy_q <= sumy_q + SUM_W'(vel_y_q[idx_q]);
						cnt_q  <= cnt_q + 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_LAST) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (cnt_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						track_q   <= 1'b1;
						div_num_q <= DIV_NW'({sx_abs, 8'b0}) + DIV_NW'(cnt_q >> 1);
						div_den_q <= DIV_DW'(cnt_q);
						div_go_q  <= 1'b1;
						state_q   <= ST_DIVX;
					end
				end
				ST_DIVX: begin
					if (div_done) begin
						avx_q     <= sumx_q[SUM_W-1] ? -div_quot[AVG_W-1:0] : div_quot[AVG_W-1:0];
						div_num_q <= DIV_NW'({sy_abs, 8'b0}) + DIV_NW'(cnt_q >> 1);
						div_den_q <= DIV_DW'(cnt_q);
						div_go_q  <= 1'b1;
						state_q   <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (div_done) begin
						avy_q   <= sumy_q[SUM_W-1] ? -div_quot[AVG_W-1:0] : div_quot[AVG_W-1:0];
						step_q  <= MS_AXDX;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// each step consumes the registered product of the previous step
					unique case (step_q)
						MS_AXDX: step_q <= MS_AYDY;
						MS_AYDY: begin dot_q <= prod_q[33:0]; step_q <= MS_DXDX; end
						MS_DXDX: begin dot_q <= dot_q + prod_q[33:0]; step_q <= MS_DYDY; end
						MS_DYDY: begin dist2_q <= prod_q[23:0]; step_q <= MS_AXAX; end
						MS_AXAX: begin dist2_q <= dist2_q + prod_q[23:0]; step_q <= MS_AYAY; end
						MS_AYAY: begin u2_q <= prod_q[41:0]; step_q <= MS_SPSP; end
						MS_SPSP: begin u2_q <= u2_q + prod_q[41:0]; step_q <= MS_AXDY; end
						MS_AXDY: begin v2_q <= {prod_q[11:0], 16'b0}; step_q <= MS_AYDX; end
						MS_AYDX: begin cr_q <= prod_q[33:0]; step_q <= MS_LIM; end
						MS_LIM:  begin cr_q <= cr_q - prod_q[33:0]; step_q <= MS_CR2; end
						MS_CR2:  begin lim_q <= prod_q[51:0]; step_q <= MS_C2; end
						MS_C2:   begin c2_q <= prod_q; state_q <= ST_DEC; end
						default: state_q <= ST_DEC;
					endcase
				end
				ST_DEC: begin
					priority if (speeds_eq) begin
						if (dot_q != '0) begin
							div_num_q <= DIV_NW'({dist2_q, 16'b0}) + DIV_NW'(dot_abs);
							div_den_q <= DIV_DW'({dot_abs, 1'b0});
							tneg_q    <= dot_q[33];
							div_go_q  <= 1'b1;
							state_q   <= ST_DIVT;
						end else begin
							state_q <= ST_OUT;
						end
					end else if (disc_pos) begin
						sq_rad_q <= disc;
						sq_go_q  <= 1'b1;
						state_q  <= ST_SQRT;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_SQRT: begin
					if (sq_done) begin
						s_q     <= sq_root;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (root_ok) begin
						div_num_q <= DIV_NW'({num_abs, 16'b0}) + DIV_NW'(den_abs >> 1);
						div_den_q <= DIV_DW'(den_abs);
						tneg_q    <= num_v[34] ^ den_v[42];
						div_go_q  <= 1'b1;
						state_q   <= ST_DIVT;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIVT: begin
					if (div_done) begin
						t_q     <= t_sat;
						step_q  <= MA_X;
						state_q <= ST_AIM;
					end
				end
				ST_AIM: begin
					priority case (step_q)
						MA_X: step_q <= MA_Y;
						MA_Y: begin aimx_q <= aim_sat; step_q <= MA_END; end
						default: begin
							aimy_q  <= aim_sat;
							aim_q   <= 1'b1;
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	tit_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	tit_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_go_q),
		.rad    (sq_rad_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign track_valid = track_q;
	assign avg_vel_x   = avx_q;
	assign avg_vel_y   = avy_q;
	assign aim_valid   = aim_q;
	assign aim_dx      = aimx_q;
	assign aim_dy      = aimy_q;

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("request taken while result pending");
	a_aim_needs_track: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && aim_valid) |-> track_valid)
		else $error("aim without track");
	a_no_track_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !track_valid) |-> (avg_vel_x == '0 && avg_vel_y == '0 && !aim_valid))
		else $error("stale fields without track");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVX || state_q == ST_DIVY || state_q == ST_DIVT))
		else $error("divider finished outside a divide step");
`endif

endmodule
`default_nettype wire
